// File: src/sgdb_pkg.sv
// Shared types and constants of the scatter-gather descriptor builder.
package sgdb_pkg;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // Register indexes, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_DEVICE_BASE  = 3'd0,
    REG_TOTAL_BYTES  = 3'd1,
    REG_START_OFFSET = 3'd2,
    REG_TO_HOST      = 3'd3,
    REG_FIRST_INDEX  = 3'd4,
    REG_RING_BASE    = 3'd5
  } reg_idx_t;

  // Descriptor kinds.
  localparam logic DESC_DATA = 1'b0;
  localparam logic DESC_LINK = 1'b1;

  typedef struct packed {
    logic [63:0] device_base_addr;
    logic [31:0] total_bytes;
    logic [31:0] start_offset;
    logic        to_host;
    logic [15:0] first_entry_index;
    logic [63:0] desc_ring_base;
  } cfg_t;

  typedef struct packed {
    logic [63:0] entry_addr;
    logic [31:0] entry_len;
    logic [15:0] entry_index;
    logic        entry_last;
  } in_item_t;

  typedef struct packed {
    logic        desc_kind;
    logic [5:0]  desc_slot;
    logic [63:0] src_addr;
    logic [63:0] dst_addr;
    logic [31:0] xfer_bytes;
    logic [63:0] link_addr;
    logic        job_done;
    logic        last_of_run;
  } out_desc_t;

  // Work handed from the front part to the back part for one entry.
  typedef struct packed {
    logic        has_data;
    logic        close;
    logic        done;
    logic [63:0] entry_addr;
    logic [31:0] offset;
    logic [31:0] xfer;
  } job_t;

endpackage

// File: src/sgdb_cfg.sv
// Configuration register file with an APB-style write and read port.
module sgdb_cfg
  import sgdb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg,
  output cfg_t                  cfg_nxt,
  output logic                  rearm
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;
  logic     hit;

  assign idx   = reg_idx_t'(paddr[5:3]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // Decode the write and form the next register contents.
  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b1;
    unique case (idx)
      REG_DEVICE_BASE:  cfg_nxt.device_base_addr  = pwdata;
      REG_TOTAL_BYTES:  cfg_nxt.total_bytes       = pwdata[31:0];
      REG_START_OFFSET: cfg_nxt.start_offset      = pwdata[31:0];
      REG_TO_HOST:      cfg_nxt.to_host           = pwdata[0];
      REG_FIRST_INDEX:  cfg_nxt.first_entry_index = pwdata[15:0];
      REG_RING_BASE:    cfg_nxt.desc_ring_base    = pwdata;
      default:          hit = 1'b0;
    endcase
    if (!wr_en) begin
      cfg_nxt = cfg_r;
    end
  end

  // Any write to a known register restarts the job.
  assign rearm = wr_en && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_DEVICE_BASE:  prdata = cfg_r.device_base_addr;
      REG_TOTAL_BYTES:  prdata = CFG_DATA_W'(cfg_r.total_bytes);
      REG_START_OFFSET: prdata = CFG_DATA_W'(cfg_r.start_offset);
      REG_TO_HOST:      prdata = CFG_DATA_W'(cfg_r.to_host);
      REG_FIRST_INDEX:  prdata = CFG_DATA_W'(cfg_r.first_entry_index);
      REG_RING_BASE:    prdata = cfg_r.desc_ring_base;
      default:          prdata = '0;
    endcase
  end

endmodule

// File: src/sgdb_front.sv
// Front part: filters entries, tracks offset, bytes owed and slot use, emits jobs.
module sgdb_front
  import sgdb_pkg::*;
#(
  parameter int MAX_SLOTS = 32,
  parameter int SW        = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  cfg_t          cfg_nxt,
  input  logic          rearm,
  input  logic          take,
  input  in_item_t      in_data,
  output logic          job_push,
  output job_t          job,
  output logic [SW-1:0] job_slot
);

  logic [31:0]   offset_left_r, offset_left_nxt;
  logic [31:0]   bytes_left_r, bytes_left_nxt;
  logic [SW-1:0] slot_count_r, slot_count_nxt;
  logic          finished_r, finished_nxt;

  logic        skip;
  logic        consume;
  logic        has_data;
  logic        close;
  logic [31:0] avail;
  logic [31:0] tr;
  logic [31:0] off_after;
  logic [31:0] bl_after;

  // Classify the entry and work out what it leaves behind.
  always_comb begin
    skip    = finished_r || (in_data.entry_index < cfg.first_entry_index);
    consume = offset_left_r > in_data.entry_len;
    avail   = in_data.entry_len - offset_left_r;
    tr      = (avail < bytes_left_r) ? avail : bytes_left_r;
    if (consume) begin
      has_data  = 1'b0;
      off_after = offset_left_r - in_data.entry_len;
      bl_after  = bytes_left_r;
      close     = in_data.entry_last;
    end else begin
      has_data  = 1'b1;
      off_after = '0;
      bl_after  = bytes_left_r - tr;
      close     = in_data.entry_last || (bl_after == '0) ||
                  (slot_count_r == SW'(MAX_SLOTS - 1));
    end

    job.has_data   = has_data;
    job.close      = close;
    job.done       = (bl_after == '0);
    job.entry_addr = in_data.entry_addr;
    job.offset     = offset_left_r;
    job.xfer       = tr;
    job_slot       = slot_count_r;
    job_push       = take && !skip && (has_data || close);
  end

  // Next state: a restart reloads everything, a usable entry advances it.
  always_comb begin
    offset_left_nxt = offset_left_r;
    bytes_left_nxt  = bytes_left_r;
    slot_count_nxt  = slot_count_r;
    finished_nxt    = finished_r;
    if (rearm) begin
      offset_left_nxt = cfg_nxt.start_offset;
      bytes_left_nxt  = cfg_nxt.total_bytes;
      slot_count_nxt  = '0;
      finished_nxt    = 1'b0;
    end else if (take && !skip) begin
      offset_left_nxt = off_after;
      bytes_left_nxt  = bl_after;
      slot_count_nxt  = close ? '0 : slot_count_r + SW'(has_data);
      finished_nxt    = close && (in_data.entry_last || (bl_after == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_left_r <= '0;
      bytes_left_r  <= '0;
      slot_count_r  <= '0;
      finished_r    <= 1'b0;
    end else begin
      offset_left_r <= offset_left_nxt;
      bytes_left_r  <= bytes_left_nxt;
      slot_count_r  <= slot_count_nxt;
      finished_r    <= finished_nxt;
    end
  end

`ifndef SYNTHESIS
  // The open batch never holds a full set of slots between entries.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_count_r < SW'(MAX_SLOTS))
    else $error("slot count reached the batch size");

  // A finished job produces no further work.
  a_no_work_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !job_push)
    else $error("job pushed after the job finished");
`endif

endmodule

// File: src/sgdb_fifo.sv
// Small job queue between the front and back parts.
module sgdb_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  // Writers and readers respect the fill level.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("job queue read while empty");
`endif

endmodule

// File: src/sgdb_back.sv
// Back part: expands each job into data and link descriptor beats.
module sgdb_back
  import sgdb_pkg::*;
#(
  parameter int DESC_STRIDE = 32,
  parameter int SW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  cfg_t          cfg_nxt,
  input  logic          rearm,
  input  logic          head_valid,
  input  job_t          head,
  input  logic [SW-1:0] head_slot,
  output logic          head_pop,
  output logic          out_valid,
  input  logic          out_take,
  output out_desc_t     out_desc
);

  localparam int STRIDE_W = $clog2(DESC_STRIDE + 1);
  localparam int PW       = SW + STRIDE_W;

  logic        phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_desc_t   out_desc_r, desc_nxt;
  logic [63:0] device_addr_r, device_addr_nxt;

  logic          out_load;
  logic          beat_is_link;
  logic [SW-1:0] link_slot;
  logic [PW-1:0] link_off;
  logic [63:0]   haddr;

  assign out_valid = out_valid_r;
  assign out_desc  = out_desc_r;

  // Beat selection and descriptor contents.
  always_comb begin
    out_load     = head_valid && (!out_valid_r || out_take);
    beat_is_link = phase_r || !head.has_data;
    head_pop     = out_load && (beat_is_link || !head.close);
    link_slot    = head_slot + SW'(head.has_data);
    link_off     = PW'(link_slot) * PW'(DESC_STRIDE);
    haddr        = head.entry_addr + 64'(head.offset);

    desc_nxt.job_done = head.done;
    if (beat_is_link) begin
      desc_nxt.desc_kind   = DESC_LINK;
      desc_nxt.desc_slot   = 6'(link_slot);
      desc_nxt.src_addr    = '0;
      desc_nxt.dst_addr    = '0;
      desc_nxt.xfer_bytes  = '0;
      desc_nxt.link_addr   = cfg.desc_ring_base + 64'(link_off);
      desc_nxt.last_of_run = 1'b1;
    end else begin
      desc_nxt.desc_kind   = DESC_DATA;
      desc_nxt.desc_slot   = 6'(head_slot);
      desc_nxt.src_addr    = cfg.to_host ? device_addr_r : haddr;
      desc_nxt.dst_addr    = cfg.to_host ? haddr : device_addr_r;
      desc_nxt.xfer_bytes  = head.xfer;
      desc_nxt.link_addr   = '0;
      desc_nxt.last_of_run = !head.close;
    end
  end

  // Control and device address next state.
  always_comb begin
    phase_nxt       = phase_r;
    out_valid_nxt   = out_valid_r;
    device_addr_nxt = device_addr_r;
    if (out_load) begin
      phase_nxt     = !beat_is_link && head.close;
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (rearm) begin
      device_addr_nxt = cfg_nxt.device_base_addr;
    end else if (out_load && !beat_is_link) begin
      device_addr_nxt = device_addr_r + 64'(head.xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      device_addr_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      out_valid_r   <= out_valid_nxt;
      device_addr_r <= device_addr_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_desc_r <= desc_nxt;
    end
  end

`ifndef SYNTHESIS
  // The link phase only exists for a job with data that closes its batch.
  a_link_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid && head.has_data && head.close))
    else $error("link phase without a matching job");
`endif

endmodule

// File: src/sg_to_dma_descriptor_builder.sv
// Top level of the scatter-gather to linked-list DMA descriptor builder.
//
// Scatter entries are pushed one per beat and come out as data descriptors, each
// batch closed by a link descriptor pointing at desc_ring_base + slot * DESC_STRIDE.
// An entry gives zero, one or two result beats. The front part accepts one entry
// per clock while its 4-deep job queue has room; the back part places one
// descriptor per clock into the output register while that register is empty or
// being popped, so an entry that gives a data and a link descriptor places them
// in turn, and a dropped entry places none. The first result of an entry goes
// through the job queue and the output register before it is on the ports. Any
// write to a known configuration register restarts the job; write only while idle.
// No clearing pass follows reset.
module sg_to_dma_descriptor_builder
  import sgdb_pkg::*;
#(
  parameter int MAX_SLOTS   = 32,
  parameter int DESC_STRIDE = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Scatter entries in
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  // Descriptors out
  output logic                  empty,
  input  logic                  pop,
  output out_desc_t             out_data
);

  localparam int SW         = $clog2(MAX_SLOTS + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int JW         = $bits(job_t);
  localparam int QW         = JW + SW;

  cfg_t          cfg;
  cfg_t          cfg_nxt;
  logic          rearm;
  logic          take;
  logic          job_push;
  job_t          job;
  logic [SW-1:0] job_slot;
  logic [QW-1:0] q_rdata;
  logic          q_full;
  logic          q_empty;
  logic          head_pop;
  job_t          head;
  logic [SW-1:0] head_slot;
  logic          out_valid;

  assign pready    = 1'b1;
  assign full      = q_full;
  assign take      = push && !q_full;
  assign head      = q_rdata[JW-1:0];
  assign head_slot = q_rdata[QW-1:JW];
  assign empty     = !out_valid;

  sgdb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .cfg_nxt (cfg_nxt),
    .rearm   (rearm)
  );

  sgdb_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .SW        (SW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cfg_nxt  (cfg_nxt),
    .rearm    (rearm),
    .take     (take),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job),
    .job_slot (job_slot)
  );

  sgdb_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (job_push),
    .wdata ({job_slot, job}),
    .rd_en (head_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  sgdb_back #(
    .DESC_STRIDE (DESC_STRIDE),
    .SW          (SW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_nxt    (cfg_nxt),
    .rearm      (rearm),
    .head_valid (!q_empty),
    .head       (head),
    .head_slot  (head_slot),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_take   (pop),
    .out_desc   (out_data)
  );

endmodule
